// ===== rtl/qte_pkg.sv =====
package qte_pkg;

	// field widths and fixed-point format
	localparam int COEF_W = 32;
	localparam int TIME_W = 20;
	localparam int FRAC_W = 16;
	localparam int SEG_W = 3;
	localparam int SLOT_W = 5;
	localparam int NSEG_W = 4;

	// polynomial shape: six terms per axis, three axes
	localparam int TERMS = 6;
	localparam int NUM_AXES = 3;
	localparam int SLOTS = TERMS * NUM_AXES;
	localparam int NUM_STEPS = TERMS - 1;

	// one lane per output polynomial
	localparam int NUM_LANES = 3 * NUM_AXES;
	localparam int LANE_POS = 0;
	localparam int LANE_VEL = NUM_AXES;
	localparam int LANE_ACC = 2 * NUM_AXES;

	// product and sum widths inside a horner step
	localparam int PROD_W = COEF_W + TIME_W + 1;
	localparam int SUM_W = PROD_W - FRAC_W + 1;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	// accumulator plus the coefficients still to be folded in (top one first)
	typedef struct packed {
		coef_t acc;
		coef_t [NUM_STEPS-1:0] k;
	} lane_t;

	// word travelling down the chain of cells
	typedef struct packed {
		lane_t [NUM_LANES-1:0] lanes;
		logic [TIME_W-1:0] t;
		logic inval;
	} word_t;

	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(32'sh7FFF_FFFF);
	localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(32'sh8000_0000);
	localparam coef_t COEF_ZERO = '0;

	// clamp a wide sum to signed q16.16
	function automatic coef_t sat32(input logic signed [SUM_W-1:0] v);
		coef_t r;
		if (v > SUM_HI) begin
			r = SUM_HI[COEF_W-1:0];
		end else if (v < SUM_LO) begin
			r = SUM_LO[COEF_W-1:0];
		end else begin
			r = v[COEF_W-1:0];
		end
		return r;
	endfunction

	// coefficient times a small constant factor, saturated
	function automatic coef_t scale_sat(input coef_t c, input logic [4:0] f);
		logic signed [SUM_W-1:0] p;
		p = SUM_W'(c) * SUM_W'($signed({1'b0, f}));
		return sat32(p);
	endfunction

endpackage

// ===== rtl/qte_if.sv =====
// request channel: loads and evaluations
interface qte_item_if;
	logic valid;
	logic ready;
	logic [0:0] func;
	logic [qte_pkg::SEG_W-1:0] segment;
	logic [qte_pkg::SLOT_W-1:0] coeff_slot;
	logic signed [qte_pkg::COEF_W-1:0] coeff_value;
	logic [qte_pkg::TIME_W-1:0] eval_time;

	modport source (
		output valid, func, segment, coeff_slot, coeff_value, eval_time,
		input ready
	);
	modport sink (
		input valid, func, segment, coeff_slot, coeff_value, eval_time,
		output ready
	);
endinterface

// result channel: position, velocity and acceleration on three axes
interface qte_result_if;
	logic valid;
	logic ready;
	logic signed [qte_pkg::COEF_W-1:0] pos_x;
	logic signed [qte_pkg::COEF_W-1:0] pos_y;
	logic signed [qte_pkg::COEF_W-1:0] pos_z;
	logic signed [qte_pkg::COEF_W-1:0] vel_x;
	logic signed [qte_pkg::COEF_W-1:0] vel_y;
	logic signed [qte_pkg::COEF_W-1:0] vel_z;
	logic signed [qte_pkg::COEF_W-1:0] acc_x;
	logic signed [qte_pkg::COEF_W-1:0] acc_y;
	logic signed [qte_pkg::COEF_W-1:0] acc_z;
	logic segment_invalid;

	modport source (
		output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		acc_x, acc_y, acc_z, segment_invalid,
		input ready
	);
	modport sink (
		input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		acc_x, acc_y, acc_z, segment_invalid,
		output ready
	);
endinterface

// ===== rtl/qte_coef_store.sv =====
module qte_coef_store #(
	parameter int DEPTH = 8,
	parameter int ADDR_W = 3
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [qte_pkg::SLOT_W-1:0] wr_slot,
	input  qte_pkg::coef_t wr_data,
	input  logic rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output qte_pkg::coef_t rd_data_s1 [qte_pkg::SLOTS]
);

	// one bank per coefficient slot, one row per segment
	qte_pkg::coef_t mem_q [qte_pkg::SLOTS][DEPTH];

	// single coefficient write
	always_ff @(posedge clk) begin
		for (int s = 0; s < qte_pkg::SLOTS; s++) begin
			if (wr_en && wr_slot == qte_pkg::SLOT_W'(s)) begin
				mem_q[s][wr_addr] <= wr_data;
			end
		end
	end

	// whole segment read, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			for (int s = 0; s < qte_pkg::SLOTS; s++) begin
				rd_data_s1[s] <= mem_q[s][rd_addr];
			end
		end
	end

endmodule

// ===== rtl/qte_cell.sv =====
module qte_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  qte_pkg::word_t word_in,
	output logic vld_out,
	output qte_pkg::word_t word_out
);

	logic vld_q;
	qte_pkg::word_t word_q;
	qte_pkg::word_t nxt;
	qte_pkg::coef_t acc_new [qte_pkg::NUM_LANES];

	// one horner step per lane: acc*t, floor shift, add next coefficient, clamp
	for (genvar g = 0; g < qte_pkg::NUM_LANES; g++) begin : g_lane
		logic signed [qte_pkg::PROD_W-1:0] prod;
		logic signed [qte_pkg::SUM_W-1:0] sum;

		assign prod = $signed(word_in.lanes[g].acc) * $signed({1'b0, word_in.t});
		assign sum = qte_pkg::SUM_W'(prod >>> qte_pkg::FRAC_W)
			+ qte_pkg::SUM_W'($signed(word_in.lanes[g].k[qte_pkg::NUM_STEPS-1]));
		assign acc_new[g] = qte_pkg::sat32(sum);
	end

	// hand remaining coefficients on, next one moved to the top
	always_comb begin
		nxt = word_in;
		for (int l = 0; l < qte_pkg::NUM_LANES; l++) begin
			nxt.lanes[l].acc = acc_new[l];
			nxt.lanes[l].k = {word_in.lanes[l].k[qte_pkg::NUM_STEPS-2:0], qte_pkg::COEF_ZERO};
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	// stage word
	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign word_out = word_q;

endmodule

// ===== rtl/quintic_trajectory_evaluator_unit.sv =====
// Piecewise quintic trajectory evaluator.
// The item channel carries two kinds of word. A load (func 0) writes one
// signed q16.16 coefficient into slot axis*6+power of a segment and gives
// no result; loads with a slot above 17 or a segment beyond the memory are
// dropped. An evaluate (func 1) takes a segment and an unsigned q4.16 time
// and gives one word on the result channel: saturated position, velocity
// and acceleration for x, y and z, by Horner's rule.
// cfg_we/cfg_wdata set num_segments; segments at or above it evaluate to
// zeros with segment_invalid set. Write it only while the block is idle.
// Throughput: one item per cycle while the receiver does not stall. An
// evaluate passes through the memory read, derivative scaling, then five
// Horner cells, one multiply-add per lane each. A load takes effect for
// any evaluate accepted in a later cycle.
// Reset clears num_segments and all stage valids; the coefficient memory is
// not cleared and must be loaded before a segment is evaluated.
// When the receiver stalls, the result word holds and the stages behind it
// keep filling; item ready falls only once every stage holds a word.
module quintic_trajectory_evaluator_unit #(
	parameter int MAX_SEGMENTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	qte_item_if.sink item,
	qte_result_if.source result,
	input  logic cfg_we,
	input  logic [qte_pkg::NSEG_W-1:0] cfg_wdata
);

	localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	logic [qte_pkg::NSEG_W-1:0] num_segments_q;
	logic accept;
	logic is_eval;
	logic is_load;
	logic seg_in_mem;
	logic seg_ok;
	logic slot_ok;
	logic [ADDR_W+qte_pkg::SEG_W-1:0] seg_wide;
	logic [ADDR_W-1:0] seg_addr;

	logic en_s1;
	logic en_s2;
	logic vld_s1;
	logic [qte_pkg::TIME_W-1:0] time_s1;
	logic inval_s1;
	qte_pkg::coef_t rd_s1 [qte_pkg::SLOTS];

	logic vld_s2;
	qte_pkg::word_t word_s2;
	qte_pkg::word_t build;

	logic cell_en [qte_pkg::NUM_STEPS+1];
	logic cell_vld [qte_pkg::NUM_STEPS+1];
	qte_pkg::word_t cell_word [qte_pkg::NUM_STEPS+1];
	qte_pkg::word_t out_word;

	// segment count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_segments_q <= '0;
		end else if (cfg_we) begin
			num_segments_q <= cfg_wdata;
		end
	end

	// decode of the incoming word
	assign accept = item.valid && item.ready;
	assign is_eval = item.func == qte_pkg::FUNC_EVAL;
	assign is_load = item.func == qte_pkg::FUNC_LOAD;
	assign seg_in_mem = 32'(item.segment) < MAX_SEGMENTS;
	assign seg_ok = seg_in_mem && ({1'b0, item.segment} < num_segments_q);
	assign slot_ok = item.coeff_slot < qte_pkg::SLOT_W'(qte_pkg::SLOTS);
	assign seg_wide = (ADDR_W + qte_pkg::SEG_W)'(item.segment);
	assign seg_addr = seg_wide[ADDR_W-1:0];

	// stage advance: a stage moves when empty or when the next one moves
	assign cell_en[qte_pkg::NUM_STEPS] = result.ready;
	for (genvar g = 0; g < qte_pkg::NUM_STEPS; g++) begin : g_en
		assign cell_en[g] = !cell_vld[g+1] || cell_en[g+1];
	end
	assign en_s2 = !vld_s2 || cell_en[0];
	assign en_s1 = !vld_s1 || en_s2;
	assign item.ready = en_s1;

	// coefficient memory, read of a whole segment
	qte_coef_store #(
		.DEPTH (MAX_SEGMENTS),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk       (clk),
		.wr_en     (accept && is_load && slot_ok && seg_in_mem),
		.wr_addr   (seg_addr),
		.wr_slot   (item.coeff_slot),
		.wr_data   (item.coeff_value),
		.rd_en     (en_s1),
		.rd_addr   (seg_addr),
		.rd_data_s1(rd_s1)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= accept && is_eval;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			time_s1 <= item.eval_time;
			inval_s1 <= !seg_ok;
		end
	end

	// derivative coefficients and lane set-up; lower-order polynomials start
	// from a zero accumulator so every lane takes the same number of steps
	always_comb begin
		build = '0;
		build.t = time_s1;
		build.inval = inval_s1;
		if (!inval_s1) begin
			for (int a = 0; a < qte_pkg::NUM_AXES; a++) begin
				build.lanes[qte_pkg::LANE_POS+a].acc = rd_s1[a*qte_pkg::TERMS+5];
				build.lanes[qte_pkg::LANE_POS+a].k = {
					rd_s1[a*qte_pkg::TERMS+4], rd_s1[a*qte_pkg::TERMS+3],
					rd_s1[a*qte_pkg::TERMS+2], rd_s1[a*qte_pkg::TERMS+1],
					rd_s1[a*qte_pkg::TERMS]
				};
				build.lanes[qte_pkg::LANE_VEL+a].k = {
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+5], 5'd5),
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+4], 5'd4),
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+3], 5'd3),
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+2], 5'd2),
					rd_s1[a*qte_pkg::TERMS+1]
				};
				build.lanes[qte_pkg::LANE_ACC+a].k = {
					qte_pkg::COEF_ZERO,
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+5], 5'd20),
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+4], 5'd12),
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+3], 5'd6),
					qte_pkg::scale_sat(rd_s1[a*qte_pkg::TERMS+2], 5'd2)
				};
			end
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			word_s2 <= build;
		end
	end

	// chain of horner cells, the last one is the result register
	assign cell_vld[0] = vld_s2;
	assign cell_word[0] = word_s2;
	for (genvar g = 0; g < qte_pkg::NUM_STEPS; g++) begin : g_cell
		qte_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (cell_en[g]),
			.vld_in  (cell_vld[g]),
			.word_in (cell_word[g]),
			.vld_out (cell_vld[g+1]),
			.word_out(cell_word[g+1])
		);
	end

	// result word
	assign out_word = cell_word[qte_pkg::NUM_STEPS];
	assign result.valid = cell_vld[qte_pkg::NUM_STEPS];
	assign result.pos_x = out_word.lanes[qte_pkg::LANE_POS].acc;
	assign result.pos_y = out_word.lanes[qte_pkg::LANE_POS+1].acc;
	assign result.pos_z = out_word.lanes[qte_pkg::LANE_POS+2].acc;
	assign result.vel_x = out_word.lanes[qte_pkg::LANE_VEL].acc;
	assign result.vel_y = out_word.lanes[qte_pkg::LANE_VEL+1].acc;
	assign result.vel_z = out_word.lanes[qte_pkg::LANE_VEL+2].acc;
	assign result.acc_x = out_word.lanes[qte_pkg::LANE_ACC].acc;
	assign result.acc_y = out_word.lanes[qte_pkg::LANE_ACC+1].acc;
	assign result.acc_z = out_word.lanes[qte_pkg::LANE_ACC+2].acc;
	assign result.segment_invalid = out_word.inval;

	// an accepted evaluate always enters stage 1
	a_eval_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_eval) |=> vld_s1)
		else $error("evaluate word did not enter stage 1");

	// a load never produces a pipeline word
	a_load_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_load) |=> !vld_s1)
		else $error("load word entered the pipeline");

	// a blocked stage 2 keeps its word
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !cell_en[0]) |=> (vld_s2 && $stable(word_s2)))
		else $error("stage 2 word lost while blocked");

	// an invalid segment gives zero results
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.segment_invalid) |->
		(result.pos_x == '0 && result.vel_y == '0 && result.acc_z == '0))
		else $error("invalid segment result not zero");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import qte_pkg::*;

	localparam int MAX_SEG = 8;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS = 75;

	localparam coef_t Q_MAX = 32'sh7FFF_FFFF;
	localparam coef_t Q_MIN = 32'sh8000_0000;
	localparam coef_t Q_ONE = 32'sh0001_0000;
	localparam logic [TIME_W-1:0] T_MAX = 20'hF_FFFF;
	localparam logic [TIME_W-1:0] T_ONE = 20'h1_0000;

	// one word on the request channel
	typedef struct {
		func_t func;
		logic [SEG_W-1:0] segment;
		logic [SLOT_W-1:0] slot;
		coef_t value;
		logic [TIME_W-1:0] eval_time;
	} traj_word_t;

	// kinematics of one evaluated sample
	typedef struct packed {
		coef_t pos_x;
		coef_t pos_y;
		coef_t pos_z;
		coef_t vel_x;
		coef_t vel_y;
		coef_t vel_z;
		coef_t acc_x;
		coef_t acc_y;
		coef_t acc_z;
		logic inval;
	} kin_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [NSEG_W-1:0] cfg_wdata;

	qte_item_if item_ch();
	qte_result_if result_ch();

	quintic_trajectory_evaluator_unit #(
		.MAX_SEGMENTS(MAX_SEG)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the coefficient store and segment count
	coef_t coeff_mem [MAX_SEG][SLOTS];
	logic [NSEG_W-1:0] num_seg;
	kin_t pending_kin[$];
	int error_count;

	bit src_idle_en;
	bit snk_idle_en;
	int sink_hold;
	int sink_gap;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	function automatic coef_t rand_coef();
		int r;
		case ($urandom_range(0, 4))
			0: begin
				return coef_t'($urandom);
			end
			1, 2: begin
				// within +/-4.0 so most results stay unsaturated
				r = $urandom_range(0, 32'h0008_0000);
				return coef_t'(r - 32'sh0004_0000);
			end
			3: begin
				r = $urandom_range(0, 32'h0000_4000);
				return coef_t'(r - 32'sh0000_2000);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return coef_t'(-1);
					3: return Q_ONE;
					default: return COEF_ZERO;
				endcase
			end
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(0, 5))
			0, 1: return TIME_W'($urandom_range(0, T_MAX));
			2, 3: return TIME_W'($urandom_range(0, 20'h2_0000));
			4: return TIME_W'($urandom_range(0, 20'h0_1000));
			default: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return T_MAX;
					default: return T_ONE;
				endcase
			end
		endcase
	endfunction

	function automatic traj_word_t mk_load(input logic [SEG_W-1:0] seg,
			input logic [SLOT_W-1:0] slot, input coef_t value);
		traj_word_t w;
		w.func = FUNC_LOAD;
		w.segment = seg;
		w.slot = slot;
		w.value = value;
		w.eval_time = TIME_W'($urandom);
		return w;
	endfunction

	function automatic traj_word_t mk_eval(input logic [SEG_W-1:0] seg,
			input logic [TIME_W-1:0] t);
		traj_word_t w;
		w.func = FUNC_EVAL;
		w.segment = seg;
		w.slot = SLOT_W'($urandom);
		w.value = coef_t'($urandom);
		w.eval_time = t;
		return w;
	endfunction

	// q16.16 clamp of a wide value
	function automatic coef_t clamp_q16(input longint v);
		if (v > longint'(Q_MAX)) return Q_MAX;
		if (v < longint'(Q_MIN)) return Q_MIN;
		return coef_t'(v);
	endfunction

	// nested multiply-add, product floored back to q16.16 each step
	function automatic coef_t horner_q16(input coef_t k[TERMS], input int n,
			input logic [TIME_W-1:0] t);
		longint acc;
		longint tl;
		int i;
		tl = longint'(t);
		acc = longint'(k[n-1]);
		for (i = n - 2; i >= 0; i--) begin
			acc = longint'(clamp_q16(((acc * tl) >>> FRAC_W) + longint'(k[i])));
		end
		return coef_t'(acc);
	endfunction

	function automatic kin_t predict_kinematics(input logic [SEG_W-1:0] seg,
			input logic [TIME_W-1:0] t);
		kin_t k;
		coef_t c[TERMS];
		coef_t dv[TERMS];
		coef_t da[TERMS];
		coef_t p_ax[NUM_AXES];
		coef_t v_ax[NUM_AXES];
		coef_t a_ax[NUM_AXES];
		int ax;
		int j;
		k = '0;
		if (int'(seg) >= int'(num_seg) || int'(seg) >= MAX_SEG) begin
			k.inval = 1'b1;
			return k;
		end
		for (ax = 0; ax < NUM_AXES; ax++) begin
			for (j = 0; j < TERMS; j++) begin
				c[j] = coeff_mem[seg][ax*TERMS + j];
				dv[j] = COEF_ZERO;
				da[j] = COEF_ZERO;
			end
			// derivative coefficients, saturated
			for (j = 0; j < TERMS - 1; j++) begin
				dv[j] = clamp_q16(longint'(j + 1) * longint'(c[j+1]));
			end
			for (j = 0; j < TERMS - 2; j++) begin
				da[j] = clamp_q16(longint'((j + 2) * (j + 1)) * longint'(c[j+2]));
			end
			p_ax[ax] = horner_q16(c, TERMS, t);
			v_ax[ax] = horner_q16(dv, TERMS - 1, t);
			a_ax[ax] = horner_q16(da, TERMS - 2, t);
		end
		k.pos_x = p_ax[0];
		k.pos_y = p_ax[1];
		k.pos_z = p_ax[2];
		k.vel_x = v_ax[0];
		k.vel_y = v_ax[1];
		k.vel_z = v_ax[2];
		k.acc_x = a_ax[0];
		k.acc_y = a_ax[1];
		k.acc_z = a_ax[2];
		return k;
	endfunction

	// update the shadow store or queue the expected sample
	function automatic void apply_word(input traj_word_t w);
		if (w.func == FUNC_LOAD) begin
			if (int'(w.slot) < SLOTS && int'(w.segment) < MAX_SEG) begin
				coeff_mem[w.segment][w.slot] = w.value;
			end
		end else begin
			pending_kin.push_back(predict_kinematics(w.segment, w.eval_time));
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// drive one word, keep valid high across back-to-back words
	task automatic send_word(input traj_word_t w);
		int gap;
		gap = src_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= w.func;
		item_ch.segment <= w.segment;
		item_ch.coeff_slot <= w.slot;
		item_ch.coeff_value <= w.value;
		item_ch.eval_time <= w.eval_time;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		apply_word(w);
	endtask

	// stop sending and let the pipeline empty
	task automatic drain_block();
		item_ch.valid <= 1'b0;
		while (pending_kin.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_num_segments(input logic [NSEG_W-1:0] v);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		num_seg = v;
	endtask

	// result word receiver: random stalls plus an on-demand long hold
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			result_ch.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (sink_gap > 0) begin
			result_ch.ready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else begin
			result_ch.ready <= 1'b1;
			sink_gap <= snk_idle_en ? pick_gap() : 0;
		end
	end

	task automatic compare_field(input string name, input coef_t got, input coef_t exp);
		if (got !== exp) begin
			report_mismatch($sformatf("%s got %h expected %h", name, got, exp));
		end
	endtask

	task automatic check_result();
		kin_t exp;
		if (pending_kin.size() == 0) begin
			report_mismatch("result word with nothing expected");
			return;
		end
		exp = pending_kin.pop_front();
		compare_field("pos_x", result_ch.pos_x, exp.pos_x);
		compare_field("pos_y", result_ch.pos_y, exp.pos_y);
		compare_field("pos_z", result_ch.pos_z, exp.pos_z);
		compare_field("vel_x", result_ch.vel_x, exp.vel_x);
		compare_field("vel_y", result_ch.vel_y, exp.vel_y);
		compare_field("vel_z", result_ch.vel_z, exp.vel_z);
		compare_field("acc_x", result_ch.acc_x, exp.acc_x);
		compare_field("acc_y", result_ch.acc_y, exp.acc_y);
		compare_field("acc_z", result_ch.acc_z, exp.acc_z);
		if (result_ch.segment_invalid !== exp.inval) begin
			report_mismatch($sformatf("segment_invalid got %b expected %b",
				result_ch.segment_invalid, exp.inval));
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			check_result();
		end
	end

	// watchdog on cycles with no word moving
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// segments 0 and 7 read invalid while the count is zero
	task automatic test_invalid_at_reset();
		send_word(mk_eval(3'd0, '0));
		send_word(mk_eval(3'd7, T_MAX));
	endtask

	// fill the whole store before any segment is valid, plus three dropped slots and one rewrite
	task automatic test_fill_memory();
		int seg;
		int slot;
		for (seg = 0; seg < MAX_SEG; seg++) begin
			for (slot = 0; slot < SLOTS; slot++) begin
				send_word(mk_load(SEG_W'(seg), SLOT_W'(slot), rand_coef()));
			end
		end
		send_word(mk_load(3'd0, 5'd18, Q_MAX));
		send_word(mk_load(3'd7, 5'd31, Q_MIN));
		send_word(mk_load(3'd3, 5'd21, coef_t'($urandom)));
		send_word(mk_load(3'd4, 5'd10, coef_t'($urandom)));
	endtask

	// known shapes, saturation both ways, time extremes
	task automatic test_directed_shapes();
		int p;
		write_num_segments(4'd8);
		// x axis of segment 0: coefficient p+1, small enough to stay exact at t=1
		for (p = 0; p < TERMS; p++) begin
			send_word(mk_load(3'd0, SLOT_W'(p), coef_t'((p + 1) * Q_ONE)));
		end
		send_word(mk_eval(3'd0, '0));
		send_word(mk_eval(3'd0, T_ONE));
		send_word(mk_eval(3'd0, T_MAX));
		// segment 7: x all max, y all min
		for (p = 0; p < TERMS; p++) begin
			send_word(mk_load(3'd7, SLOT_W'(p), Q_MAX));
			send_word(mk_load(3'd7, SLOT_W'(TERMS + p), Q_MIN));
		end
		send_word(mk_eval(3'd7, T_MAX));
		send_word(mk_eval(3'd7, '0));
		// out-of-range slot must leave segment 0 untouched
		send_word(mk_load(3'd0, 5'd31, Q_MIN));
		send_word(mk_eval(3'd0, T_ONE));
	endtask

	// valid boundary at several segment counts
	task automatic test_config_bounds();
		write_num_segments(4'd3);
		send_word(mk_eval(3'd2, rand_time()));
		send_word(mk_eval(3'd3, rand_time()));
		write_num_segments(4'd15);
		send_word(mk_eval(3'd7, rand_time()));
		write_num_segments(4'd0);
		send_word(mk_eval(3'd0, rand_time()));
		write_num_segments(4'd1);
		send_word(mk_eval(3'd0, rand_time()));
		send_word(mk_eval(3'd1, rand_time()));
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		int n;
		write_num_segments(4'd8);
		src_idle_en = 1'b0;
		sink_hold <= HOLD_CYCLES;
		for (n = 0; n < 40; n++) begin
			send_word(mk_eval(SEG_W'($urandom_range(0, 7)), rand_time()));
		end
		src_idle_en = 1'b1;
	endtask

	// mostly loads and evaluations with random content, some dropped loads
	task automatic test_random_phases();
		logic [NSEG_W-1:0] settings[6];
		int ph;
		int n;
		int r;
		logic [SEG_W-1:0] seg;
		settings[0] = 4'd8;
		settings[1] = 4'd0;
		settings[2] = 4'd15;
		settings[3] = NSEG_W'($urandom_range(2, 7));
		settings[4] = 4'd1;
		settings[5] = 4'd8;
		for (ph = 0; ph < 6; ph++) begin
			write_num_segments(settings[ph]);
			src_idle_en = (ph != 2);
			snk_idle_en = (ph != 2) && (ph != 4);
			for (n = 0; n < PHASE_WORDS; n++) begin
				r = $urandom_range(0, 99);
				seg = SEG_W'($urandom_range(0, 7));
				if (r < 55) begin
					send_word(mk_eval(seg, rand_time()));
				end else if (r < 92) begin
					send_word(mk_load(seg, SLOT_W'($urandom_range(0, SLOTS - 1)), rand_coef()));
				end else begin
					send_word(mk_load(seg, SLOT_W'($urandom_range(SLOTS, 31)), rand_coef()));
				end
			end
		end
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.func = '0;
		item_ch.segment = '0;
		item_ch.coeff_slot = '0;
		item_ch.coeff_value = '0;
		item_ch.eval_time = '0;
		result_ch.ready = 1'b0;
		sink_hold = 0;
		sink_gap = 0;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		error_count = 0;
		num_seg = '0;
		foreach (coeff_mem[s, k]) coeff_mem[s][k] = COEF_ZERO;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_invalid_at_reset();
		test_fill_memory();
		test_directed_shapes();
		test_config_bounds();
		test_backpressure();
		test_random_phases();

		drain_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_kin.size() != 0) begin
			report_mismatch($sformatf("%0d result words never arrived", pending_kin.size()));
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
